// File: design/dsd_pkg.sv
// Shared types, widths and constants for the decimal to seven-segment block.
// Used by the front end, the command queue, the digit back end and the top level.
`default_nettype none

package dsd_pkg;

	localparam int NUM_W    = 27;
	localparam int DOT_W    = 8;
	localparam int POS_W    = 4;
	localparam int SEG_W    = 8;
	localparam int DIGITS_DEFAULT = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [NUM_W-1:0] MAX_SHOWN = 27'd99999999;

	// Reciprocal of ten scaled by 2**30, rounded up. Exact quotient for all
	// values below 2**27.
	localparam logic [NUM_W-1:0] RECIP_TEN = 27'd107374183;
	localparam int RECIP_SHIFT = 30;

	localparam logic [SEG_W-1:0] DOT_BIT = 8'b1000_0000;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [DOT_W-1:0] dot_mask;
		logic [POS_W-1:0] start_pos;
		logic [POS_W-1:0] stop_pos;
		logic             leading_zeros;
	} cmd_t;

	function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
		logic [SEG_W-1:0] seg;
		case (digit)
			4'd0: seg = 8'h7E;
			4'd1: seg = 8'h30;
			4'd2: seg = 8'h6D;
			4'd3: seg = 8'h79;
			4'd4: seg = 8'h33;
			4'd5: seg = 8'h5B;
			4'd6: seg = 8'h5F;
			4'd7: seg = 8'h70;
			4'd8: seg = 8'h7F;
			4'd9: seg = 8'h7B;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

// File: design/decimal_to_seven_segment_digits.sv
// Decimal number to seven-segment display writes, one write per digit position.
// Throughput: one write a cycle while the output is empty or popped. The digit unit
// takes the next item only after the last write of the current one, and a request
// that is rejected takes no time there. Asynchronous active-low reset empties the
// command queue and the result register; no other clearing is needed.
`default_nettype none

module decimal_to_seven_segment_digits import dsd_pkg::*; #(
	parameter int DIGITS = DIGITS_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [NUM_W-1:0] number,
	input  wire logic [DOT_W-1:0] dot_mask,
	input  wire logic [POS_W-1:0] start_pos,
	input  wire logic [POS_W-1:0] field_len,
	input  wire logic             leading_zeros,
	output logic                  empty,
	input  wire logic             pop,
	output logic [POS_W-1:0]      digit_pos,
	output logic [SEG_W-1:0]      segments,
	output logic                  last
);

	cmd_t front_cmd;
	logic front_ok;
	cmd_t q_cmd;
	logic q_empty;
	logic q_pop;

	dsd_front #(
		.DIGITS(DIGITS)
	) u_front (
		.number(number),
		.dot_mask(dot_mask),
		.start_pos(start_pos),
		.field_len(field_len),
		.leading_zeros(leading_zeros),
		.cmd(front_cmd),
		.cmd_ok(front_ok)
	);

	// Requests that fail the front-end checks are accepted and dropped here.
	dsd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push && !full && front_ok),
		.wr_data(front_cmd),
		.full(full),
		.rd_en(q_pop),
		.rd_data(q_cmd),
		.empty(q_empty)
	);

	dsd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(q_cmd),
		.cmd_empty(q_empty),
		.cmd_pop(q_pop),
		.digit_pos(digit_pos),
		.segments(segments),
		.last(last),
		.empty(empty),
		.pop(pop)
	);

endmodule

`default_nettype wire

// File: design/dsd_front.sv
// Request front end: checks a request and works out its last position.
// Depends on dsd_pkg for the command type and widths.
`default_nettype none

module dsd_front import dsd_pkg::*; #(
	parameter int DIGITS = DIGITS_DEFAULT
) (
	input  wire logic [NUM_W-1:0] number,
	input  wire logic [DOT_W-1:0] dot_mask,
	input  wire logic [POS_W-1:0] start_pos,
	input  wire logic [POS_W-1:0] field_len,
	input  wire logic             leading_zeros,
	output cmd_t                  cmd,
	output logic                  cmd_ok
);

	logic [POS_W:0] stop_raw;

	always_comb begin
		stop_raw = {1'b0, start_pos} + {1'b0, field_len} - {{POS_W{1'b0}}, 1'b1};
		cmd_ok = (number <= MAX_SHOWN) && (field_len != '0) && (start_pos != '0) &&
			(start_pos <= POS_W'(DIGITS));
		cmd.number        = number;
		cmd.dot_mask      = dot_mask;
		cmd.start_pos     = start_pos;
		cmd.leading_zeros = leading_zeros;
		// A field that runs past the display ends at the last digit.
		if (stop_raw > (POS_W+1)'(DIGITS)) begin
			cmd.stop_pos = POS_W'(DIGITS);
		end else begin
			cmd.stop_pos = stop_raw[POS_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: design/dsd_queue.sv
// Short command queue between the front end and the digit back end.
// Depends on dsd_pkg for the command type.
`default_nettype none

module dsd_queue import dsd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/dsd_back.sv
// Digit back end: peels one decimal digit a cycle unless the output stalls, and writes one position.
// Depends on dsd_pkg for the font, the reciprocal constant and the command type.
`default_nettype none

module dsd_back import dsd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic             cmd_empty,
	output logic                  cmd_pop,
	output logic [POS_W-1:0]      digit_pos,
	output logic [SEG_W-1:0]      segments,
	output logic                  last,
	output logic                  empty,
	input  wire logic             pop
);

	logic                 busy_q;
	logic [NUM_W-1:0]     num_q;
	logic [DOT_W-1:0]     dots_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     start_q;
	logic [POS_W-1:0]     stop_q;
	logic                 lz_q;
	logic                 out_valid_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [SEG_W-1:0]     out_seg_q;
	logic                 out_last_q;

	logic [2*NUM_W-1:0]   prod;
	logic [NUM_W-1:0]     quot;
	logic [NUM_W-1:0]     times_ten;
	logic [NUM_W-1:0]     rem_full;
	logic [SEG_W-1:0]     seg;
	logic [2:0]           dot_idx;
	logic                 emit;

	always_comb begin
		// Divide by ten through the scaled reciprocal; the remainder follows.
		prod      = {{NUM_W{1'b0}}, num_q} * {{NUM_W{1'b0}}, RECIP_TEN};
		quot      = NUM_W'(prod >> RECIP_SHIFT);
		times_ten = (quot << 3) + (quot << 1);
		rem_full  = num_q - times_ten;
		if (num_q != '0) begin
			seg = seg_font(rem_full[3:0]);
		end else if (lz_q || (pos_q == start_q)) begin
			seg = seg_font(4'd0);
		end else begin
			seg = '0;
		end
		dot_idx = 3'(pos_q - 1'b1);
		if (dots_q[dot_idx]) begin
			seg = seg | DOT_BIT;
		end
	end

	assign cmd_pop   = !busy_q && !cmd_empty;
	assign emit      = busy_q && (!out_valid_q || pop);
	assign empty     = !out_valid_q;
	assign digit_pos = out_pos_q;
	assign segments  = out_seg_q;
	assign last      = out_last_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			num_q   <= cmd.number;
			dots_q  <= cmd.dot_mask;
			pos_q   <= cmd.start_pos;
			start_q <= cmd.start_pos;
			stop_q  <= cmd.stop_pos;
			lz_q    <= cmd.leading_zeros;
		end else if (emit) begin
			num_q <= quot;
			pos_q <= pos_q + 1'b1;
		end
		if (emit) begin
			out_pos_q  <= pos_q;
			out_seg_q  <= seg;
			out_last_q <= (pos_q == stop_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				busy_q <= 1'b1;
			end else if (emit && (pos_q == stop_q)) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
